// ----- sv/modexp_pkg.sv -----
// Package for the modular exponentiation unit: operand width and state type.
// Depends on nothing; every other file imports it.
`default_nettype none
package modexp_pkg;
   localparam int unsigned OPERAND_WIDTH = 32;
   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned CNT_WIDTH = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0] operand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- sv/modexp_if.sv -----
// Valid/ready channel interfaces for the modular exponentiation unit.
// Depends on modexp_pkg.
`default_nettype none
interface modexp_req_if import modexp_pkg::*; ();
   logic valid;
   logic ready;
   logic [FIELD_WIDTH-1:0] base;
   logic [FIELD_WIDTH-1:0] exponent;
   logic [FIELD_WIDTH-1:0] modulus;
   modport source (output valid, base, exponent, modulus, input ready);
   modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
   logic valid;
   logic ready;
   logic [FIELD_WIDTH-1:0] power_mod;
   modport source (output valid, power_mod, input ready);
   modport sink (input valid, power_mod, output ready);
endinterface
`default_nettype wire

// ----- sv/modexp_mulmod.sv -----
// Bit-serial modular multiplier: one doubling and one conditional add per cycle.
// Depends on modexp_pkg. Operands must lie below the modulus.
`default_nettype none
module modexp_mulmod import modexp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire operand_type a,
   input  wire operand_type b,
   input  wire operand_type m,
   output      logic        busy,
   output      logic        done,
   output      operand_type product
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   operand_type          acc_ff, acc_in;
   operand_type          b_ff, b_in;
   logic [OPERAND_WIDTH:0] dbl, dbl_red, sum;
   operand_type          acc_dbl;

   always_comb begin
      // Doubling then adding stay one bit wider than the modulus before correction.
      dbl = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      acc_dbl = dbl_red[OPERAND_WIDTH-1:0];
      sum = {1'b0, acc_dbl} + {1'b0, a};
      if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      b_in = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_WIDTH'(OPERAND_WIDTH - 1);
         acc_in = '0;
         b_in = b;
      end else if (busy_ff) begin
         acc_in = b_ff[OPERAND_WIDTH-1] ? sum[OPERAND_WIDTH-1:0] : acc_dbl;
         b_in = {b_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff <= b_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign product = acc_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier finished without running");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while busy");
   a_acc_below_mod: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> acc_ff < m)
      else $error("accumulator not reduced");
endmodule
`default_nettype wire

// ----- sv/modexp_reduce.sv -----
// Bit-serial restoring remainder of the base by the modulus, one quotient bit per cycle.
// Depends on modexp_pkg.
`default_nettype none
module modexp_reduce import modexp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire operand_type x,
   input  wire operand_type m,
   output      logic        done,
   output      operand_type rem
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   operand_type          rem_ff, rem_in;
   operand_type          x_ff, x_in;
   logic [OPERAND_WIDTH:0] trial;

   always_comb begin
      trial = {rem_ff, x_ff[OPERAND_WIDTH-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      x_in = x_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_WIDTH'(OPERAND_WIDTH - 1);
         rem_in = '0;
         x_in = x;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, m}) ? OPERAND_WIDTH'(trial - {1'b0, m})
                                        : trial[OPERAND_WIDTH-1:0];
         x_in = {x_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      x_ff <= x_in;
   end

   assign done = done_ff;
   assign rem = rem_ff;
endmodule
`default_nettype wire

// ----- sv/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: one item at a time. After a transfer the base is reduced,
// then for each of the 32 exponent bits from the top a square and, for a set bit, a
// multiply follow, each in the shared bit-serial multiplier. A zero exponent or a modulus
// of one or zero goes straight to the done state. The result waits in an output register.
// Depends on modexp_pkg, modexp_if, modexp_reduce and modexp_mulmod.
`default_nettype none
module modular_exponentiation_unit import modexp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   modexp_req_if.sink   req,
   modexp_rsp_if.source rsp
);
   state_type            state_ff, state_in;
   operand_type          exp_ff, exp_in;
   operand_type          mod_ff, mod_in;
   operand_type          base_ff, base_in;
   operand_type          base_raw_ff, base_raw_in;
   operand_type          r_ff, r_in;
   logic [CNT_WIDTH-1:0] bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                 red_start;
   logic                 red_done;
   operand_type          red_rem;
   logic                 mul_start;
   logic                 mul_busy;
   logic                 mul_done;
   operand_type          mul_b;
   operand_type          mul_p;
   logic                 take;

   assign take = req.valid && req.ready;

   // The reducer captures its operand at the start edge, so it takes the base as it arrives.
   modexp_reduce u_reduce (
      .clock(clock), .reset(reset), .start(red_start),
      .x(base_raw_in), .m(mod_ff), .done(red_done), .rem(red_rem)
   );

   modexp_mulmod u_mulmod (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(state_ff == ST_MULT ? base_ff : r_ff), .b(mul_b), .m(mod_ff),
      .busy(mul_busy), .done(mul_done), .product(mul_p)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (take) begin
               if (OPERAND_WIDTH'(req.exponent) == '0 || OPERAND_WIDTH'(req.modulus) <= 1)
                  state_in = ST_DONE;
               else
                  state_in = ST_REDUCE;
            end
         ST_REDUCE: if (red_done) state_in = ST_SQUARE;
         ST_SQUARE:
            if (mul_done) begin
               if (exp_ff[bit_ff]) state_in = ST_MULT;
               else if (bit_ff == '0) state_in = ST_DONE;
            end
         ST_MULT:
            if (mul_done) state_in = (bit_ff == '0) ? ST_DONE : ST_SQUARE;
         ST_DONE: if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      exp_in = exp_ff;
      mod_in = mod_ff;
      base_in = base_ff;
      base_raw_in = base_raw_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      red_start = 1'b0;
      mul_start = 1'b0;
      mul_b = r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in = rsp_data_ff;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (take) begin
               exp_in = OPERAND_WIDTH'(req.exponent);
               mod_in = OPERAND_WIDTH'(req.modulus);
               base_raw_in = OPERAND_WIDTH'(req.base);
               bit_in = CNT_WIDTH'(OPERAND_WIDTH - 1);
               r_in = (OPERAND_WIDTH'(req.exponent) == '0) ? OPERAND_WIDTH'(1) : '0;
               red_start = 1'b1;
            end
         end
         ST_REDUCE:
            if (red_done) begin
               base_in = red_rem;
               r_in = OPERAND_WIDTH'(1);
               mul_start = 1'b1;
            end
         ST_SQUARE:
            if (mul_done) begin
               r_in = mul_p;
               if (exp_ff[bit_ff]) mul_start = 1'b1;
               else if (bit_ff != '0) begin
                  bit_in = bit_ff - 1'b1;
                  mul_start = 1'b1;
               end
            end
         ST_MULT: begin
            mul_b = r_ff;
            if (mul_done) begin
               r_in = mul_p;
               if (bit_ff != '0) begin
                  bit_in = bit_ff - 1'b1;
                  mul_start = 1'b1;
               end
            end
         end
         ST_DONE:
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = FIELD_WIDTH'(r_ff);
            end
         default: ;
      endcase
      // A square multiplies the running value by itself; a multiply by the base.
      if (mul_start) mul_b = r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff <= exp_in;
      mod_ff <= mod_in;
      base_ff <= base_in;
      base_raw_ff <= base_raw_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.power_mod = rsp_data_ff;

   a_idle_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_busy)
      else $error("multiplier running while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result dropped before transfer");
   a_start_excl: assert property (@(posedge clock) disable iff (reset)
      !(red_start && mul_start))
      else $error("both units started together");
endmodule
`default_nettype wire

// ----- sim/modexp_checker.sv -----
// Checker for the modular exponentiation unit: watches both channels, predicts each
// result by square-and-multiply and compares it. Depends on modexp_pkg and modexp_if.
`default_nettype none
module modexp_checker import modexp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   modexp_req_if    req,
   modexp_rsp_if    rsp,
   output int       fail_count,
   output int       pending
);
   logic [FIELD_WIDTH-1:0] power_queue[$];

   function automatic logic [FIELD_WIDTH-1:0] predict_power(
      logic [FIELD_WIDTH-1:0] base_in, logic [FIELD_WIDTH-1:0] exp_in,
      logic [FIELD_WIDTH-1:0] mod_in);
      logic [127:0] b;
      logic [127:0] m;
      logic [127:0] r;
      b = 128'(operand_type'(base_in));
      m = 128'(operand_type'(mod_in));
      if (operand_type'(exp_in) == '0) return 1;
      if (m <= 1) return 0;
      b = b % m;
      r = 1;
      for (int i = OPERAND_WIDTH - 1; i >= 0; i--) begin
         r = (r * r) % m;
         if (exp_in[i]) r = (r * b) % m;
      end
      return r[FIELD_WIDTH-1:0];
   endfunction

   assign pending = power_queue.size();

   always @(posedge clock) begin
      logic [FIELD_WIDTH-1:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready)
            power_queue.push_back(predict_power(req.base, req.exponent, req.modulus));
         if (rsp.valid && rsp.ready) begin
            if (power_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("Unexpected result transfer: %h", rsp.power_mod);
            end else begin
               want = power_queue.pop_front();
               if (rsp.power_mod !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("power_mod mismatch: expected %h, got %h", want, rsp.power_mod);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ----- sim/tb_modular_exponentiation_unit.sv -----
// Testbench top for the modular exponentiation unit: drives directed and random operands
// with bursty traffic and a stalling receiver. Depends on modexp_pkg, modexp_if, modexp_checker.
`default_nettype none
module tb_modular_exponentiation_unit;
   import modexp_pkg::*;

   localparam int WATCHDOG_LIMIT = 30000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   int   stall_phase = 0;

   modexp_req_if req ();
   modexp_rsp_if rsp ();

   modular_exponentiation_unit i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   modexp_checker i_checker (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending(pending));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver runs free for a while, then stalls on a random pattern.
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 200) % 2 == 0) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** modular_exponentiation_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_operands(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      req.base     <= b;
      req.exponent <= e;
      req.modulus  <= m;
      req.valid    <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 15);
         3: return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] m;
      int burst;
      req.valid = 1'b0;
      req.base = '0;
      req.exponent = '0;
      req.modulus = 32'd1;
      rsp.ready = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero exponent, modulus of one and zero, extremes of every field.
      send_operands(32'd7, 32'd0, 32'd13);
      send_operands(32'd7, 32'd0, 32'd1);
      send_operands(32'd7, 32'd0, 32'd0);
      send_operands(32'hFFFF_FFFF, 32'd5, 32'd1);
      send_operands(32'd3, 32'd5, 32'd0);
      send_operands(32'd0, 32'd5, 32'd97);
      send_operands(32'd0, 32'd0, 32'd97);
      send_operands(32'd2, 32'd10, 32'd1000);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      send_operands(32'd123456789, 32'd1, 32'd1000);
      send_operands(32'd5, 32'h8000_0000, 32'd2);
      send_operands(32'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFB);
      send_operands(32'hFFFF_FFFF, 32'd2, 32'd3);
      pause_sender();

      for (int n = 0; n < 280; n += burst) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst; k++) begin
            m = random_word();
            send_operands(random_word(), random_word(), m);
         end
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
      req.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("** modular_exponentiation_unit: PASSED **");
      else $display("** modular_exponentiation_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
